>>> design/rkt_pkg.sv
// shared types and constants for the recent key table
`default_nettype none

package rkt_pkg;

    localparam int KEY_W  = 64;
    localparam int SEC_W  = 32;
    localparam int DAY_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CNT_OW = 4;

    // day = seconds / 86400 = (seconds >> 7) / 675, done as a reciprocal multiply
    localparam int          SEC_LSB   = 7;
    localparam int          NUM_W     = SEC_W - SEC_LSB;
    localparam int          RECIP_W   = 26;
    localparam int          PROD_W    = NUM_W + RECIP_W;
    localparam int          DAY_SHIFT = 35;
    localparam logic [RECIP_W-1:0] DAY_RECIP = 26'd50903317;

    localparam logic [CFG_W-1:0] EXPIRY_DAYS_RST = 16'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic [SEC_W-1:0] now_seconds;
    } t_item;

    typedef struct packed {
        logic              was_present;
        logic [CNT_OW-1:0] expired_count;
        logic              oldest_dropped;
        logic [CNT_OW-1:0] live_count;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [DAY_W-1:0] day;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic shift;
        logic front;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic shift_done;
    } t_status;

endpackage

`default_nettype wire

>>> design/rkt_ram.sv
// generic single write port ram with registered read
`default_nettype none

module rkt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rkt_ctrl.sv
// sequencer for expiry scan, insertion shift and front write
`default_nettype none

module rkt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                o_busy,
    output rkt_pkg::t_cmd       o_cmd,
    input  wire rkt_pkg::t_status i_status,
    output logic                o_result_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FRONT
    } t_state_e;

    t_state_e r_state;
    logic     r_result_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (i_status.scan_done) begin
                        if (i_status.hit) begin
                            r_state        <= ST_IDLE;
                            r_result_valid <= 1'b1;
                        end else begin
                            r_state <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT: begin
                    if (i_status.shift_done) begin
                        r_state <= ST_FRONT;
                    end
                end
                ST_FRONT: begin
                    r_state        <= ST_IDLE;
                    r_result_valid <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == ST_IDLE) && i_start;
        o_cmd.scan  = (r_state == ST_SCAN);
        o_cmd.shift = (r_state == ST_SHIFT);
        o_cmd.front = (r_state == ST_FRONT);
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_result_valid;

endmodule

`default_nettype wire

>>> design/rkt_dpath.sv
// entry memory, day computation, scan and shift pointers, result registers
`default_nettype none

module rkt_dpath #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rkt_pkg::t_cmd              i_cmd,
    output rkt_pkg::t_status                o_status,
    input  wire rkt_pkg::t_item             i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [rkt_pkg::CFG_W-1:0]  i_cfg_wdata,
    output rkt_pkg::t_result                o_result
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST = CW'(TABLE_DEPTH - 1);
    localparam int ENTRY_W_L = rkt_pkg::ENTRY_W;

    logic [rkt_pkg::CFG_W-1:0]   r_exp_days;
    logic [rkt_pkg::KEY_W-1:0]   r_key;
    logic [rkt_pkg::DAY_W-1:0]   r_today;
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_rd_ptr;
    logic [CW-1:0]               r_w;
    logic [CW-1:0]               r_exp;
    logic                        r_pend;
    logic                        r_hit;
    logic                        r_drop;
    logic [CW-1:0]               r_sh;
    logic                        r_sh_pend;
    logic [IW-1:0]               r_sh_wa;

    logic [rkt_pkg::PROD_W-1:0]  prod;
    logic [ENTRY_W_L-1:0]        ram_rdata;
    rkt_pkg::t_entry             entry;
    rkt_pkg::t_entry             wentry;
    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [IW-1:0]               ram_raddr;
    logic [CW-1:0]               sh_m1;
    logic                        keep;
    logic                        match;
    logic                        scan_done;
    logic                        shift_done;
    logic [CW-1:0]               top;

    assign prod = rkt_pkg::PROD_W'(i_item.now_seconds[rkt_pkg::SEC_W-1:rkt_pkg::SEC_LSB])
                * rkt_pkg::PROD_W'(rkt_pkg::DAY_RECIP);

    assign entry = rkt_pkg::t_entry'(ram_rdata);
    // entry expires when its day is not later than today and is at least the limit behind
    assign keep  = !((r_today >= entry.day) && ((r_today - entry.day) >= r_exp_days));
    assign match = (entry.key == r_key) && !r_hit;

    assign scan_done  = (r_rd_ptr == r_cnt) && !r_pend;
    assign shift_done = (r_sh == '0) && !r_sh_pend;
    assign top        = (r_w == FULL) ? LAST : r_w;
    assign sh_m1      = r_sh - CW'(1);

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = '0;
        wentry     = '0;
        ram_raddr  = i_cmd.shift ? sh_m1[IW-1:0] : r_rd_ptr[IW-1:0];
        if (i_cmd.scan && r_pend && keep) begin
            ram_we     = 1'b1;
            ram_waddr  = r_w[IW-1:0];
            wentry.key = entry.key;
            wentry.day = match ? r_today : entry.day;
        end else if (i_cmd.shift && r_sh_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_sh_wa;
            wentry    = entry;
        end else if (i_cmd.front) begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            wentry.key = r_key;
            wentry.day = r_today;
        end
    end

    rkt_ram #(
        .WIDTH (ENTRY_W_L),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wentry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_days <= rkt_pkg::EXPIRY_DAYS_RST;
            r_cnt      <= '0;
            r_rd_ptr   <= '0;
            r_w        <= '0;
            r_exp      <= '0;
            r_pend     <= 1'b0;
            r_hit      <= 1'b0;
            r_drop     <= 1'b0;
            r_sh       <= '0;
            r_sh_pend  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_days <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_key    <= i_item.key_id;
                r_today  <= prod[rkt_pkg::DAY_SHIFT +: rkt_pkg::DAY_W];
                r_rd_ptr <= '0;
                r_w      <= '0;
                r_exp    <= '0;
                r_pend   <= 1'b0;
                r_hit    <= 1'b0;
                r_drop   <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (!scan_done) begin
                    r_pend <= (r_rd_ptr < r_cnt);
                    if (r_rd_ptr < r_cnt) begin
                        r_rd_ptr <= r_rd_ptr + CW'(1);
                    end
                    if (r_pend) begin
                        if (keep) begin
                            r_w <= r_w + CW'(1);
                            if (match) begin
                                r_hit <= 1'b1;
                            end
                        end else begin
                            r_exp <= r_exp + CW'(1);
                        end
                    end
                end else begin
                    // survivors are packed, set up the insertion shift
                    r_cnt     <= r_w;
                    r_drop    <= !r_hit && (r_w == FULL);
                    r_sh      <= top;
                    r_sh_pend <= 1'b0;
                end
            end
            if (i_cmd.shift) begin
                if (r_sh != '0) begin
                    r_sh_pend <= 1'b1;
                    r_sh_wa   <= r_sh[IW-1:0];
                    r_sh      <= sh_m1;
                end else begin
                    r_sh_pend <= 1'b0;
                end
            end
            if (i_cmd.front) begin
                r_cnt <= (r_cnt == FULL) ? FULL : r_cnt + CW'(1);
            end
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.scan_done  = scan_done;
        o_status.hit        = r_hit;
        o_status.shift_done = shift_done;
    end

    always_comb begin
        o_result                = '0;
        o_result.was_present    = r_hit;
        o_result.expired_count  = rkt_pkg::CNT_OW'(r_exp);
        o_result.oldest_dropped = r_drop;
        o_result.live_count     = rkt_pkg::CNT_OW'(r_cnt);
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("live count above table depth");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_w <= r_rd_ptr))
        else $error("compaction write passed the read pointer");

    a_scan_accounting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> ((CW+1)'(r_w) + (CW+1)'(r_exp) + (CW+1)'(r_pend)
                        == (CW+1)'(r_rd_ptr)))
        else $error("scan lost or duplicated an entry");
`endif

endmodule

`default_nettype wire

>>> design/recent_key_table_with_expiry.sv
// top level of the recent key table with day based expiry
//
// channel   direction  signals                      transfer
// item      in         start, busy, i_item          start high while busy low
// result    out        o_result_valid, o_result     one cycle strobe, always taken
// config    in         i_cfg_we, i_cfg_wdata        write enable high
//
// busy stays high while the entries held before the item are walked for expiry and, on a miss,
// while those left after expiry, at most TABLE_DEPTH-1, move back one place and the new key
// is written at the front; both walks run through the single write port memory.
// the result strobe comes in the first cycle with busy low, when a new item may already start.
// reset clears the live count, so the table starts empty with no clearing pass.
// results cannot be stalled; config writes are taken in any cycle.
`default_nettype none

module recent_key_table_with_expiry #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire rkt_pkg::t_item             i_item,
    output logic                            o_result_valid,
    output rkt_pkg::t_result                o_result,
    input  wire logic                       i_cfg_we,
    input  wire logic [rkt_pkg::CFG_W-1:0]  i_cfg_wdata
);

    rkt_pkg::t_cmd    cmd;
    rkt_pkg::t_status status;

    rkt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .o_cmd          (cmd),
        .i_status       (status),
        .o_result_valid (o_result_valid)
    );

    rkt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    a_hit_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.was_present && o_result.oldest_dropped))
        else $error("refresh reported a dropped entry");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_valid))
        else $error("accepted item did not raise busy");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !$past(o_result_valid)))
        else $error("result strobe without a finished item");
`endif

endmodule

`default_nettype wire
